/* rtl/rrs_pkg.sv */
package rrs_pkg;

  // Default table depth
  localparam int unsigned NumStripesDef = 256;

  // Field widths
  localparam int unsigned TimeW  = 64;
  localparam int unsigned CountW = 9;
  localparam int unsigned SidxW  = 8;
  localparam int unsigned CfgIdxW = 2;

  // Stream data widths (byte padded)
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 144;

  // Request kinds carried in tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_POLL  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETENTION = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GUARD     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_JOBS  = 2'd3;

  // Result bit positions used by the checker
  localparam int unsigned OutDecValidBit = 0;
  localparam int unsigned OutDeferBit    = 74;

endpackage

/* rtl/retention_refresh_scheduler_top.sv */
// Earliest-deadline-first refresh scheduler.
// Input stream (s_axis_*): tuser selects the request kind. A write request
// replaces one stripe entry; it produces no result.
// A poll request scans the whole stripe table and produces one result on
// the output stream (m_axis_*).
// A poll reads the table memory one entry per cycle through its single read
// port, followed by a four stage evaluation pipeline (deadline add, guard
// subtract, compare, minimum update), a drain state that waits for the
// pipeline to empty, and the output register. One request is handled at a
// time: no new request is taken until a poll's result has been loaded.
// The result register parts the two sides: while a result waits for
// m_axis_tready_i, write requests and the next poll are still taken; that
// poll only finishes once the previous result has been delivered.
// Reset clears the configuration to its defaults and then runs a clearing
// pass that marks every stripe inactive; s_axis_tready_o
// stays low until it ends. Configuration writes are taken at any time but
// must only be issued while no request is in flight.
module retention_refresh_scheduler_top
  import rrs_pkg::*;
#(
  parameter int unsigned NUM_STRIPES = NumStripesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TimeW-1:0]    cfg_data_i,
  // request stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: stripe_index[7:0], entry_active[8], entry_sealed[9],
  //        entry_has_data[10], retention_start[74:11], now_time[138:75],
  //        active_jobs[147:139], free_stripes[156:148], zero pad[159:157]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: action (0 write, 1 poll)
  input  logic                s_axis_tuser_i,
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: decision_valid[0], decision_stripe[8:1], decision_deadline[72:9],
  //        deadline_late[73], no_space_defer[74], next_check_valid[75],
  //        next_check_time[139:76], zero pad[143:140]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW   = (NUM_STRIPES > 1) ? $clog2(NUM_STRIPES) : 1;
  localparam int unsigned EntryW = 3 + TimeW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Request field unpacking
  logic [SidxW-1:0]  in_sidx;
  logic [2:0]        in_flags;
  logic [TimeW-1:0]  in_ret_start;
  logic [TimeW-1:0]  in_now;
  logic [CountW-1:0] in_jobs;
  logic [CountW-1:0] in_free;

  assign in_sidx      = s_axis_tdata_i[7:0];
  assign in_flags     = s_axis_tdata_i[10:8];
  assign in_ret_start = s_axis_tdata_i[74:11];
  assign in_now       = s_axis_tdata_i[138:75];
  assign in_jobs      = s_axis_tdata_i[147:139];
  assign in_free      = s_axis_tdata_i[156:148];

  // Configuration registers
  logic              enable_q;
  logic [TimeW-1:0]  ret_time_q;
  logic [TimeW-1:0]  guard_q;
  logic [CountW-1:0] max_jobs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      ret_time_q <= '0;
      guard_q    <= '0;
      max_jobs_q <= CountW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE:    enable_q   <= cfg_data_i[0];
        CFG_RETENTION: ret_time_q <= cfg_data_i;
        CFG_GUARD:     guard_q    <= cfg_data_i;
        CFG_MAX_JOBS:  max_jobs_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  state_e            state_q;
  logic [IdxW-1:0]   cnt_q;
  logic              m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q;
  logic [TimeW-1:0]  now_q;
  logic [CountW-1:0] jobs_q;
  logic [CountW-1:0] free_q;

  logic in_acc, wr_acc, poll_acc, cnt_last, out_free;
  logic [IdxW+SidxW-1:0] wr_addr_ext;
  logic                  wr_in_range;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_acc   = in_acc && (s_axis_tuser_i == ACT_WRITE);
  assign poll_acc = in_acc && (s_axis_tuser_i == ACT_POLL);
  assign cnt_last = (cnt_q == IdxW'(NUM_STRIPES - 1));
  assign out_free = !m_tvalid_q || m_axis_tready_i;

  assign wr_addr_ext = {{IdxW{1'b0}}, in_sidx};
  assign wr_in_range = (32'(in_sidx) < NUM_STRIPES);

  // Table memory: flags in [2:0], retention start above
  logic [EntryW-1:0] mem_q [NUM_STRIPES];
  logic [EntryW-1:0] rd_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [EntryW-1:0] mem_wdata;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_acc && wr_in_range;
      mem_waddr = wr_addr_ext[IdxW-1:0];
      mem_wdata = {in_ret_start, in_flags};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[cnt_q];
  end

  // Evaluation pipeline
  logic              v1_q, v2_q, v3_q, v4_q;
  logic [IdxW-1:0]   idx1_q, idx2_q, idx3_q, idx4_q;
  logic              el2_q, el3_q, el4_q;
  logic [TimeW-1:0]  dl2_q, dl3_q, dl4_q;
  logic [TimeW-1:0]  trig3_q, trig4_q;
  logic              later4_q;
  logic              nxt_vld_q, due_vld_q;
  logic [TimeW-1:0]  nxt_time_q, due_dl_q;
  logic [IdxW-1:0]   due_idx_q;

  logic [TimeW:0]    dl_sum;
  logic [TimeW:0]    trig_diff;

  assign dl_sum    = {1'b0, rd_q[EntryW-1:3]} + {1'b0, ret_time_q};
  assign trig_diff = {1'b0, dl2_q} - {1'b0, guard_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= (state_q == ST_SCAN);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Payload stages: saturating deadline, floored trigger, future compare
  always_ff @(posedge clk_i) begin
    idx1_q   <= cnt_q;
    idx2_q   <= idx1_q;
    el2_q    <= (rd_q[2:0] == 3'b111);
    dl2_q    <= dl_sum[TimeW] ? '1 : dl_sum[TimeW-1:0];
    idx3_q   <= idx2_q;
    el3_q    <= el2_q;
    dl3_q    <= dl2_q;
    trig3_q  <= trig_diff[TimeW] ? '0 : trig_diff[TimeW-1:0];
    idx4_q   <= idx3_q;
    el4_q    <= el3_q;
    dl4_q    <= dl3_q;
    trig4_q  <= trig3_q;
    later4_q <= (trig3_q > now_q);
  end

  // Running minimum of future triggers and of due deadlines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_vld_q  <= 1'b0;
      nxt_time_q <= '0;
      due_vld_q  <= 1'b0;
      due_dl_q   <= '0;
      due_idx_q  <= '0;
    end else if (poll_acc) begin
      nxt_vld_q <= 1'b0;
      due_vld_q <= 1'b0;
    end else if (v4_q && el4_q) begin
      if (later4_q) begin
        if (!nxt_vld_q || (trig4_q < nxt_time_q)) begin
          nxt_vld_q  <= 1'b1;
          nxt_time_q <= trig4_q;
        end
      end else if (!due_vld_q || (dl4_q < due_dl_q)) begin
        // strict compare keeps the lower index on ties
        due_vld_q <= 1'b1;
        due_dl_q  <= dl4_q;
        due_idx_q <= idx4_q;
      end
    end
  end

  // Result assembly
  logic                 fire, dec_valid, missed, deferred, nxt_vld;
  logic [IdxW+SidxW-1:0] due_idx_ext;
  logic [SidxW-1:0]     dec_stripe;
  logic [TimeW-1:0]     dec_deadline, nxt_time;
  logic [OutDataW-1:0]  res_data;

  assign fire         = enable_q && due_vld_q && !(jobs_q >= max_jobs_q);
  assign dec_valid    = fire && (free_q != '0);
  assign deferred     = fire && (free_q == '0);
  assign missed       = fire && (now_q > due_dl_q);
  assign dec_deadline = fire ? due_dl_q : '0;
  assign due_idx_ext  = {{SidxW{1'b0}}, due_idx_q};
  assign dec_stripe   = dec_valid ? due_idx_ext[SidxW-1:0] : '0;
  assign nxt_vld      = enable_q && nxt_vld_q;
  assign nxt_time     = nxt_vld ? nxt_time_q : '0;
  assign res_data     = {4'b0, nxt_time, nxt_vld, deferred, missed, dec_deadline,
                         dec_stripe, dec_valid};

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      now_q      <= '0;
      jobs_q     <= '0;
      free_q     <= '0;
    end else begin
      // a result loaded in ST_DONE takes over the slot in the same cycle
      if (m_tvalid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (cnt_last) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end
        ST_IDLE: begin
          if (poll_acc) begin
            now_q   <= in_now;
            jobs_q  <= in_jobs;
            free_q  <= in_free;
            cnt_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_last) begin
            cnt_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end
        ST_DRAIN: begin
          if (!(v1_q || v2_q || v3_q || v4_q)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= res_data;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

endmodule

/* rtl/rrs_checker.sv */
module rrs_checker
  import rrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_o,
  input  logic                s_axis_tuser_i,
  input  logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  input  logic [OutDataW-1:0] m_axis_tdata_o
);

  // Polls accepted whose result has not yet been taken
  logic [1:0] pend_q;
  logic       poll_in, res_out;

  assign poll_in = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_POLL);
  assign res_out = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (poll_in && !res_out) begin
      pend_q <= (pend_q == 2'd3) ? pend_q : pend_q + 2'd1;
    end else if (res_out && !poll_in) begin
      pend_q <= (pend_q == 2'd0) ? pend_q : pend_q - 2'd1;
    end
  end

  // A result only follows an accepted poll
  a_res_has_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (pend_q != 2'd0))
    else $error("result without an outstanding poll");

  // At most one poll in work and one result waiting
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many polls outstanding");

  // A decision and a deferral never appear together
  a_dec_xor_defer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[OutDecValidBit] && m_axis_tdata_o[OutDeferBit]))
    else $error("decision and deferral both set");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind retention_refresh_scheduler_top rrs_checker u_rrs_checker (.*);
